FILE: rtl/core/mlp_pkg.sv
// Shared types and constants for the two-layer perceptron inference unit.
// Used by the controller, the datapath and the top level.
package mlp_pkg;
	localparam int MaxInputs  = 16384;
	localparam int MaxHidden  = 128;
	localparam int MaxOutputs = 16;
	localparam int InW  = $clog2(MaxInputs);
	localparam int HidW = $clog2(MaxHidden);
	localparam int OutW = $clog2(MaxOutputs);
	localparam int AccW = 48;

	localparam logic [2:0] ActW1 = 3'd0;
	localparam logic [2:0] ActB1 = 3'd1;
	localparam logic [2:0] ActW2 = 3'd2;
	localparam logic [2:0] ActB2 = 3'd3;
	localparam logic [2:0] ActSample = 3'd4;

	localparam logic [1:0] RegInputCount  = 2'd0;
	localparam logic [1:0] RegHiddenCount = 2'd1;
	localparam logic [1:0] RegOutputCount = 2'd2;

	typedef enum logic [2:0] {
		OP_IDLE, OP_W1, OP_B1, OP_W2, OP_B2, OP_MAC, OP_ACT, OP_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [HidW-1:0]  hid;
		logic [OutW-1:0]  outu;
		logic             first;
		logic             last_hid;
		logic             last_out;
	} cmd_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage

FILE: rtl/core/mlp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mlp_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/mlp_ctrl.sv
// Controller: sequences loads, the per-sample MAC sweep, activation and output sweeps.
// Depends on mlp_pkg.
module mlp_ctrl import mlp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       action,
	input  logic [InW-1:0]   input_index,
	input  logic [InW:0]     n_in,
	input  logic [HidW:0]    n_hid,
	input  logic [OutW:0]    n_out,
	input  logic             res_busy,
	output cmd_t             cmd
);
	typedef enum logic [2:0] {S_IDLE, S_MAC, S_ACT, S_OUT, S_WAIT, S_FLUSH} state_t;
	state_t state_q;
	logic [HidW-1:0] h_q;
	logic [OutW-1:0] o_q;
	logic lastvec_q;
	logic accept;
	logic [HidW:0] hend;
	logic hlast, olast;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign hend = n_hid - 1'b1;
	assign hlast = ({1'b0, h_q} == hend);
	assign olast = ({1'b0, o_q} == n_out - 1'b1);

	always_comb begin
		cmd = '0;
		cmd.op = OP_IDLE;
		cmd.hid = h_q;
		cmd.outu = o_q;
		cmd.first = (h_q == '0);
		cmd.last_hid = hlast;
		cmd.last_out = olast;
		if (accept) begin
			case (action)
				ActW1: cmd.op = OP_W1;
				ActB1: cmd.op = OP_B1;
				ActW2: cmd.op = OP_W2;
				ActB2: cmd.op = OP_B2;
				default: cmd.op = OP_IDLE;
			endcase
		end
		case (state_q)
			S_MAC: cmd.op = OP_MAC;
			S_ACT: cmd.op = OP_ACT;
			S_OUT: cmd.op = res_busy ? OP_IDLE : OP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q <= '0;
			o_q <= '0;
			lastvec_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept && action == ActSample && {1'b0, input_index} < n_in) begin
					state_q <= S_MAC;
					h_q <= '0;
					lastvec_q <= ({1'b0, input_index} == n_in - 1'b1);
				end
				S_MAC: begin
					if (hlast) begin
						h_q <= '0;
						o_q <= '0;
						state_q <= lastvec_q ? S_FLUSH : S_WAIT;
					end else h_q <= h_q + 1'b1;
				end
				S_FLUSH: begin
					if (h_q[0]) begin
						h_q <= '0;
						state_q <= S_ACT;
					end else h_q <= h_q + 1'b1;
				end
				S_ACT: begin
					if (hlast) begin
						h_q <= '0;
						state_q <= S_OUT;
					end else h_q <= h_q + 1'b1;
				end
				S_OUT: if (!res_busy) begin
					if (olast) state_q <= S_WAIT;
					else begin
						o_q <= o_q + 1'b1;
						state_q <= S_ACT;
					end
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/mlp_dp.sv
// Datapath: weight RAMs, hidden accumulators, shared multiplier and result register.
// Depends on mlp_pkg and mlp_ram.
module mlp_dp import mlp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [InW-1:0]      input_index,
	input  logic [HidW-1:0]     hidden_index,
	input  logic [OutW-1:0]     output_index,
	input  logic signed [15:0]  value,
	input  logic                out_stall,
	output logic                res_busy,
	output logic                out_valid,
	output logic [OutW-1:0]     result_index,
	output logic signed [15:0]  logit,
	output logic                class_bit,
	output logic                last
);
	logic [InW-1:0] ii_q;
	logic signed [15:0] x_q;
	logic [InW+HidW-1:0] w1_ra;
	logic [15:0] w1_rd, b1_rd, w2_rd, b2_rd;
	logic [HidW+OutW-1:0] w2_ra;
	logic [AccW-1:0] acc_rdata;

	logic acc_we;
	logic [HidW-1:0] acc_wa;
	logic [AccW-1:0] acc_wd;

	// stage 1 control
	op_t op_s1;
	logic [HidW-1:0] h_s1;
	logic [OutW-1:0] o_s1;
	logic first_s1;
	logic signed [31:0] prod_s2;
	op_t op_s2;
	logic [HidW-1:0] h_s2;
	logic [OutW-1:0] o_s2;
	logic first_s2, lo_s1, lo_s2;
	logic signed [AccW-1:0] accv_s2;
	logic signed [15:0] b1_s2, w2_s2, b2_s2;
	logic signed [15:0] act_s2;
	logic signed [63:0] osum_q;
	logic signed [63:0] zsum;

	// zero-valid bits for the hidden accumulators (cleared on reset and after each vector)
	logic [MaxHidden-1:0] accv_q;
	logic acc_ok_s1;

	always_ff @(posedge clk) begin
		if (cmd.op != OP_MAC) begin
			ii_q <= input_index;
			x_q <= value;
		end
	end

	assign w1_ra = (cmd.op == OP_MAC) ? {ii_q, cmd.hid} : {input_index, hidden_index};
	assign w2_ra = {cmd.hid, cmd.outu};

	mlp_ram #(.Width(16), .Depth(MaxInputs*MaxHidden)) u_w1 (
		.clk, .we(cmd.op == OP_W1), .waddr({input_index, hidden_index}), .wdata(value),
		.raddr(w1_ra), .rdata(w1_rd));
	mlp_ram #(.Width(16), .Depth(MaxHidden)) u_b1 (
		.clk, .we(cmd.op == OP_B1), .waddr(hidden_index), .wdata(value),
		.raddr(cmd.hid), .rdata(b1_rd));
	mlp_ram #(.Width(16), .Depth(MaxHidden*MaxOutputs)) u_w2 (
		.clk, .we(cmd.op == OP_W2), .waddr({hidden_index, output_index}), .wdata(value),
		.raddr(w2_ra), .rdata(w2_rd));
	mlp_ram #(.Width(16), .Depth(MaxOutputs)) u_b2 (
		.clk, .we(cmd.op == OP_B2), .waddr(output_index), .wdata(value),
		.raddr(cmd.outu), .rdata(b2_rd));
	mlp_ram #(.Width(AccW), .Depth(MaxHidden)) u_acc (
		.clk, .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
		.raddr(cmd.hid), .rdata(acc_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_IDLE;
			op_s2 <= OP_IDLE;
		end else begin
			op_s1 <= (cmd.op == OP_MAC || cmd.op == OP_ACT || cmd.op == OP_OUT) ? cmd.op : OP_IDLE;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		h_s1 <= cmd.hid;
		o_s1 <= cmd.outu;
		first_s1 <= cmd.first;
		lo_s1 <= cmd.last_out;
		acc_ok_s1 <= accv_q[cmd.hid];
		h_s2 <= h_s1;
		o_s2 <= o_s1;
		first_s2 <= first_s1;
		lo_s2 <= lo_s1;
		accv_s2 <= acc_ok_s1 ? acc_rdata : '0;
		b1_s2 <= b1_rd;
		w2_s2 <= w2_rd;
		b2_s2 <= b2_rd;
		prod_s2 <= x_q * $signed(w1_rd);
	end

	assign zsum = 64'(accv_s2) + (64'(b1_s2) <<< 12);
	always_comb begin
		act_s2 = '0;
		if (zsum > 0) act_s2 = sat16(zsum >>> 12);
	end

	// MAC sweep: read-modify-write of one hidden accumulator per cycle
	assign acc_we = (op_s2 == OP_MAC);
	assign acc_wa = h_s2;
	assign acc_wd = accv_s2 + AccW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) accv_q <= '0;
		else if (op_s2 == OP_MAC) accv_q[h_s2] <= 1'b1;
		else if (op_s2 == OP_OUT && lo_s2) accv_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (op_s2 == OP_ACT) osum_q <= (first_s2 ? (64'(b2_s2) <<< 12) : osum_q)
			+ 64'(act_s2) * 64'(w2_s2);
	end

	logic ov_q;
	assign res_busy = (ov_q && out_stall) || op_s1 == OP_OUT || op_s2 == OP_OUT;
	assign out_valid = ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (op_s2 == OP_OUT) ov_q <= 1'b1;
		else if (!out_stall) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (op_s2 == OP_OUT) begin
			result_index <= o_s2;
			logit <= sat16(osum_q >>> 12);
			class_bit <= (osum_q > 0);
			last <= lo_s2;
		end
	end
endmodule

FILE: rtl/core/mlp_relu_sigmoid_inference_unit.sv
// Two-layer perceptron inference unit: requests on the input channel load
// weights and biases or stream sample elements; results leave on the output channel.
// Load requests write their RAM and leave the unit idle. A sample request sweeps
// every hidden unit in use through one shared multiply-accumulate and the single
// accumulator RAM port; no new request is accepted until the sweep is done. The
// last element of a vector then waits in a flush state for the accumulator writes
// to land and runs, per output unit, every hidden unit through the activation and
// the second-layer multiplier, then an output step; the result passes through the
// datapath pipeline into the output register. last marks the final result of the
// vector. While the unit is busy in_stall is high. A stalled result holds the output
// register and halts the output sweep until it is taken. Reset clears the control
// state, the counts to their defaults and the hidden accumulators (by valid bits,
// no clearing pass). Weights are undefined until written. The user must ensure
// configuration is written through cfg_we/cfg_index/cfg_data only while idle; the
// block does not enforce it. Depends on mlp_pkg, mlp_ctrl, mlp_dp and mlp_ram.
module mlp_relu_sigmoid_inference_unit import mlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [13:0]        input_index,
	input  logic [6:0]         hidden_index,
	input  logic [3:0]         output_index,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         result_index,
	output logic signed [15:0] logit,
	output logic               class_bit,
	output logic               last
);
	logic [14:0] in_cnt_q;
	logic [7:0] hid_cnt_q;
	logic [4:0] out_cnt_q;
	logic [InW:0] n_in;
	logic [HidW:0] n_hid;
	logic [OutW:0] n_out;
	logic res_busy;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q <= 15'd12288;
			hid_cnt_q <= 8'd128;
			out_cnt_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegInputCount: in_cnt_q <= cfg_data;
				RegHiddenCount: hid_cnt_q <= cfg_data[7:0];
				RegOutputCount: out_cnt_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign n_in = (in_cnt_q == '0) ? (InW+1)'(1) :
		(in_cnt_q > 15'(MaxInputs)) ? (InW+1)'(MaxInputs) : in_cnt_q[InW:0];
	assign n_hid = (hid_cnt_q == '0) ? (HidW+1)'(1) :
		(hid_cnt_q > 8'(MaxHidden)) ? (HidW+1)'(MaxHidden) : hid_cnt_q[HidW:0];
	assign n_out = (out_cnt_q == '0) ? (OutW+1)'(1) :
		(out_cnt_q > 5'(MaxOutputs)) ? (OutW+1)'(MaxOutputs) : out_cnt_q[OutW:0];

	mlp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .action, .input_index,
		.n_in, .n_hid, .n_out, .res_busy, .cmd);

	mlp_dp u_dp (
		.clk, .arst_n, .cmd, .input_index, .hidden_index, .output_index, .value,
		.out_stall, .res_busy, .out_valid, .result_index, .logit, .class_bit, .last);
endmodule
